FILE: sv/mfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfc_pkg
// Shared constants, controller states and command/status bundles for the
// move-to-front codec.
// ----------------------------------------------------------------------------
package mfc_pkg;

	localparam int SYM_W             = 8;
	localparam int ALPHABET_SIZE_DEF = 256;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_FRONT
	} mfc_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // input beat accepted
		logic rd;     // issue list read at scan position
		logic chk;    // compare read entry, shift it back
		logic front;  // write chosen byte to the front and post result
	} mfc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic miss;     // encode byte outside alphabet (on the input beat)
		logic hit;      // scan reached the chosen entry
		logic out_free; // result register can take a new result
	} mfc_stat_t;

endpackage

FILE: sv/move_to_front_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_codec
// Move-to-front encoder/decoder over a byte recency list held in RAM.
// ----------------------------------------------------------------------------
//  channel  handshake                   payload
//  in       in_valid / in_ready         symbol_in, block_start
//  out      out_valid / out_ready       symbol_out
//  config   direction_we (no wait)      direction
//
//  a beat whose chosen entry sits at list position p takes one read/check pair per
//  position 0..p and a front write: the single list RAM read port scans each entry.
//  an encode byte outside the alphabet skips the scan and leaves the list as is.
//  reset and block_start clear the per-entry valid bits at once, no clearing pass.
//  the next beat is taken while a finished result still waits in the output
//  register; the front write holds until that register is free.
// ----------------------------------------------------------------------------
module move_to_front_codec #(
	parameter int ALPHABET_SIZE = mfc_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      direction_we,
	input  logic                      direction,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [mfc_pkg::SYM_W-1:0] symbol_in,
	input  logic                      block_start,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [mfc_pkg::SYM_W-1:0] symbol_out
);

	mfc_pkg::mfc_cmd_t  cmd;
	mfc_pkg::mfc_stat_t stat;

	mfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mfc_dp #(
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.direction_we (direction_we),
		.direction    (direction),
		.symbol_in    (symbol_in),
		.block_start  (block_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.symbol_out   (symbol_out),
		.cmd          (cmd),
		.stat         (stat)
	);

`ifndef SYNTHESIS
	// one beat in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted twice in a row");

	// a hit in the scan goes straight to the front write
	a_hit_to_front: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.chk && stat.hit) |=> cmd.front)
		else $error("scan hit not followed by front write");

	// a result only appears out of the front write step
	a_out_from_front: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.front))
		else $error("result posted outside front write");
`endif

endmodule

FILE: sv/mfc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfc_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mfc_ram #(
	parameter int WIDTH = mfc_pkg::SYM_W,
	parameter int DEPTH = mfc_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/mfc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfc_ctrl
// Sequencer for the list scan: accept, read/check pairs, front write.
// ----------------------------------------------------------------------------
module mfc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mfc_pkg::mfc_stat_t  stat,
	output mfc_pkg::mfc_cmd_t   cmd
);

	mfc_pkg::mfc_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mfc_pkg::ST_IDLE: begin
				if (in_valid) begin
					// out-of-alphabet byte skips the scan
					state_nxt = stat.miss ? mfc_pkg::ST_FRONT : mfc_pkg::ST_READ;
				end
			end
			mfc_pkg::ST_READ:  state_nxt = mfc_pkg::ST_CHECK;
			mfc_pkg::ST_CHECK: begin
				state_nxt = stat.hit ? mfc_pkg::ST_FRONT : mfc_pkg::ST_READ;
			end
			mfc_pkg::ST_FRONT: begin
				if (stat.out_free) begin
					state_nxt = mfc_pkg::ST_IDLE;
				end
			end
			default: state_nxt = mfc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			mfc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			mfc_pkg::ST_READ:  cmd.rd    = 1'b1;
			mfc_pkg::ST_CHECK: cmd.chk   = 1'b1;
			mfc_pkg::ST_FRONT: cmd.front = 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: sv/mfc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfc_dp
// Recency list RAM with per-entry valid bits, scan registers and the
// output register.
// ----------------------------------------------------------------------------
module mfc_dp #(
	parameter int ALPHABET_SIZE = mfc_pkg::ALPHABET_SIZE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      direction_we,
	input  logic                      direction,
	input  logic [mfc_pkg::SYM_W-1:0] symbol_in,
	input  logic                      block_start,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [mfc_pkg::SYM_W-1:0] symbol_out,
	input  mfc_pkg::mfc_cmd_t         cmd,
	output mfc_pkg::mfc_stat_t        stat
);

	localparam int AW = $clog2(ALPHABET_SIZE);
	localparam int SW = mfc_pkg::SYM_W;

	logic          dir_q;
	logic [SW-1:0] sym_q;
	logic [AW-1:0] tgt_q;
	logic          miss_q;
	logic [AW-1:0] pos_q;
	logic [SW-1:0] carry_q;
	logic [SW-1:0] chosen_q;
	logic [SW-1:0] res_q;
	logic          vld_s1;
	logic [ALPHABET_SIZE-1:0] vld_q;
	logic          out_valid_q;
	logic [SW-1:0] out_q;

	logic          over_lim;
	logic [SW-1:0] rd_data;
	logic [SW-1:0] entry;
	logic          hit;
	logic          front_fire;
	logic          we;
	logic [AW-1:0] waddr;
	logic [SW-1:0] wdata;

	// symbol past the last list position
	assign over_lim = ({1'b0, symbol_in} > (SW+1)'(ALPHABET_SIZE - 1));

	// entry never written since block start reads as its own index
	assign entry = vld_s1 ? rd_data : SW'(pos_q);
	assign hit   = (dir_q == mfc_pkg::DIR_DECODE) ? (pos_q == tgt_q) : (entry == sym_q);

	assign front_fire = cmd.front && (!out_valid_q || out_ready);

	assign we    = (cmd.chk && (pos_q != '0)) || (front_fire && !miss_q);
	assign waddr = cmd.front ? '0 : pos_q;
	assign wdata = cmd.front ? chosen_q : carry_q;

	assign stat.miss     = (dir_q == mfc_pkg::DIR_ENCODE) && over_lim;
	assign stat.hit      = hit;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign symbol_out = out_q;

	mfc_ram #(
		.WIDTH (SW),
		.DEPTH (ALPHABET_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (pos_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q       <= mfc_pkg::DIR_ENCODE;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (direction_we) begin
				dir_q <= direction;
			end
			if (cmd.load && block_start) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (front_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q  <= symbol_in;
			tgt_q  <= over_lim ? AW'(ALPHABET_SIZE - 1) : symbol_in[AW-1:0];
			miss_q <= stat.miss;
			pos_q  <= '0;
		end
		if (cmd.rd) begin
			vld_s1 <= vld_q[pos_q];
		end
		if (cmd.chk) begin
			carry_q <= entry;
			if (hit) begin
				chosen_q <= entry;
				res_q    <= (dir_q == mfc_pkg::DIR_DECODE) ? entry : SW'(pos_q);
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
		if (front_fire) begin
			out_q <= miss_q ? '0 : res_q;
		end
	end

endmodule
